@@ design/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
`default_nettype none

package spq_pkg;

  localparam int DEPTH       = 64;
  localparam int WEIGHT_BITS = 32;
  localparam int HANDLE_BITS = 16;
  localparam int COUNT_BITS  = $clog2(DEPTH + 1);

  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ design/spq_cell.sv @@
// One slot of the sorted queue: holds a weight and a handle and trades them with its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire logic               occ,
  input  wire spq_pkg::weight_t   new_weight,
  input  wire spq_pkg::handle_t   new_handle,
  input  wire logic               left_ge,
  input  wire spq_pkg::weight_t   left_weight,
  input  wire spq_pkg::handle_t   left_handle,
  input  wire spq_pkg::weight_t   right_weight,
  input  wire spq_pkg::handle_t   right_handle,
  output logic                    ge,
  output spq_pkg::weight_t        weight,
  output spq_pkg::handle_t        handle
);

  spq_pkg::weight_t weight_r, weight_nxt;
  spq_pkg::handle_t handle_r, handle_nxt;

  // An empty slot counts as heavier than anything, so the flags rise once along the row.
  assign ge     = !occ || (weight_r >= new_weight);
  assign weight = weight_r;
  assign handle = handle_r;

  always_comb begin
    weight_nxt = weight_r;
    handle_nxt = handle_r;
    if (ctl.ins) begin
      if (left_ge) begin
        weight_nxt = left_weight;
        handle_nxt = left_handle;
      end else if (ge) begin
        weight_nxt = new_weight;
        handle_nxt = new_handle;
      end
    end else if (ctl.rem) begin
      weight_nxt = right_weight;
      handle_nxt = right_handle;
    end
  end

  always_ff @(posedge clk) begin
    weight_r <= weight_nxt;
    handle_r <= handle_nxt;
  end

endmodule

`default_nettype wire

@@ design/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: the row of spq_cell slots, the entry count
// and the result register. Depends on spq_pkg and spq_cell.
//
// The queue keeps up to DEPTH entries in ascending weight order in a row of cells that all
// compare against the new weight at once, so busy stays low: a transaction may be started in
// every cycle. Its result appears on the out_ ports in the cycle after it is accepted, marked
// by out_strobe for that one cycle, and must be taken then, since the block cannot be stalled.
`default_nettype none

module sorted_priority_queue (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_kind,
  input  wire logic [spq_pkg::WEIGHT_BITS-1:0] in_item_weight,
  input  wire logic [spq_pkg::HANDLE_BITS-1:0] in_item_handle,
  output logic                                out_strobe,
  output logic [spq_pkg::WEIGHT_BITS-1:0]     out_weight,
  output logic [spq_pkg::HANDLE_BITS-1:0]     out_handle,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [spq_pkg::COUNT_BITS-1:0]      out_entry_count
);

  localparam int N = spq_pkg::DEPTH;

  spq_pkg::count_t    count_r, count_nxt;
  logic               strobe_r;
  spq_pkg::weight_t   res_weight_r, res_weight_nxt;
  spq_pkg::handle_t   res_handle_r, res_handle_nxt;
  logic               res_valid_r, res_valid_nxt;
  spq_pkg::status_t   res_status_r, res_status_nxt;
  spq_pkg::count_t    res_count_r;

  logic               accept, is_remove, full, empty;
  spq_pkg::cell_ctl_t ctl;

  logic               ge   [N];
  logic               occ  [N];
  spq_pkg::weight_t   cw   [N];
  spq_pkg::handle_t   ch   [N];

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_remove = (in_kind == spq_pkg::KIND_REMOVE);
  assign full      = (count_r == spq_pkg::count_t'(N));
  assign empty     = (count_r == '0);
  assign ctl.ins   = accept && !is_remove && !full;
  assign ctl.rem   = accept && is_remove && !empty;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic             l_ge;
      spq_pkg::weight_t l_w, r_w;
      spq_pkg::handle_t l_h, r_h;

      assign occ[gi] = (spq_pkg::count_t'(gi) < count_r);

      if (gi == 0) begin : g_first
        assign l_ge = 1'b0;
        assign l_w  = '0;
        assign l_h  = '0;
      end else begin : g_mid
        assign l_ge = ge[gi-1];
        assign l_w  = cw[gi-1];
        assign l_h  = ch[gi-1];
      end

      if (gi == N - 1) begin : g_last
        assign r_w = '0;
        assign r_h = '0;
      end else begin : g_inner
        assign r_w = cw[gi+1];
        assign r_h = ch[gi+1];
      end

      spq_cell u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .occ          (occ[gi]),
        .new_weight   (in_item_weight),
        .new_handle   (in_item_handle),
        .left_ge      (l_ge),
        .left_weight  (l_w),
        .left_handle  (l_h),
        .right_weight (r_w),
        .right_handle (r_h),
        .ge           (ge[gi]),
        .weight       (cw[gi]),
        .handle       (ch[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt      = count_r;
    res_weight_nxt = '0;
    res_handle_nxt = '0;
    res_valid_nxt  = 1'b0;
    res_status_nxt = spq_pkg::STATUS_OK;
    if (accept) begin
      if (is_remove) begin
        if (empty) begin
          res_status_nxt = spq_pkg::STATUS_EMPTY;
        end else begin
          count_nxt      = count_r - spq_pkg::count_t'(1);
          res_weight_nxt = cw[0];
          res_handle_nxt = ch[0];
          res_valid_nxt  = 1'b1;
        end
      end else begin
        if (full) begin
          res_status_nxt = spq_pkg::STATUS_FULL;
        end else begin
          count_nxt = count_r + spq_pkg::count_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    res_weight_r <= res_weight_nxt;
    res_handle_r <= res_handle_nxt;
    res_valid_r  <= res_valid_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= count_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_weight      = res_weight_r;
  assign out_handle      = res_handle_r;
  assign out_valid       = res_valid_r;
  assign out_status      = res_status_r;
  assign out_entry_count = res_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::count_t'(N))
    else $error("entry count exceeds the queue depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe && (out_entry_count == count_r))
    else $error("result does not follow an accepted transaction");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == spq_pkg::STATUS_FULL)
      |-> out_entry_count == spq_pkg::count_t'(N))
    else $error("insert dropped while the queue was not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == spq_pkg::STATUS_EMPTY) |-> out_entry_count == '0)
    else $error("remove reported empty while entries remain");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_valid |-> out_status == spq_pkg::STATUS_OK)
    else $error("returned entry carries an error status");
`endif

endmodule

`default_nettype wire
